>>> rtl/core/i2c_master_bit_engine_assert.svh
// Assertion macros used by the I2C master bit engine RTL.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Checks an implication that must hold in the same cycle, outside reset.
`define I2CM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks an implication whose consequence must hold in the next cycle.
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/i2cm_pkg.sv
// Shared types and constants of the I2C master bit engine.
package i2cm_pkg;

   localparam int HALF_PERIOD_W       = 16;
   localparam int ACK_TIMEOUT_W       = 8;
   localparam int CSR_DATA_W          = 16;
   localparam int BYTE_W              = 8;
   localparam int BIT_COUNT_W         = 4;
   localparam int DELAY_BITS_DEFAULT  = 16;
   localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd5;
   localparam logic [ACK_TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 8'd250;
   localparam logic [BIT_COUNT_W-1:0]   BITS_PER_BYTE     = 4'd8;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STOP  = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic {
      CSR_HALF_PERIOD = 1'b0,
      CSR_ACK_TIMEOUT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              cmd_valid;
      op_type            operation;
      logic [BYTE_W-1:0] tx_data;
      logic              send_ack;
      logic              sda_in;
   } req_type;

   typedef struct packed {
      logic              scl_out;
      logic              sda_out;
      logic              busy_res;
      logic              done_res;
      logic [BYTE_W-1:0] rx_data;
      logic              ack_error;
   } rsp_type;

   typedef struct packed {
      logic [HALF_PERIOD_W-1:0] half_period;
      logic [ACK_TIMEOUT_W-1:0] ack_timeout;
   } cfg_type;

endpackage

>>> rtl/core/i2cm_chan_if.sv
// Valid/ready channel interface carrying one payload per transfer.
interface i2cm_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/i2cm_csr.sv
// Configuration registers of the I2C master bit engine.
module i2cm_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  i2cm_pkg::csr_index_type        csr_index,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output i2cm_pkg::cfg_type              cfg
);

   i2cm_pkg::cfg_type cfg_ff;
   i2cm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            i2cm_pkg::CSR_HALF_PERIOD: begin
               cfg_in.half_period = csr_wdata[i2cm_pkg::HALF_PERIOD_W-1:0];
            end
            i2cm_pkg::CSR_ACK_TIMEOUT: begin
               cfg_in.ack_timeout = csr_wdata[i2cm_pkg::ACK_TIMEOUT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period <= i2cm_pkg::HALF_PERIOD_RESET;
         cfg_ff.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/i2cm_step.sv
// Bus sequencer: advances the pin sequence by one tick per accepted transfer.
`include "i2c_master_bit_engine_assert.svh"

module i2cm_step #(
   parameter int DELAY_BITS = i2cm_pkg::DELAY_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  i2cm_pkg::req_type req,
   input  i2cm_pkg::cfg_type cfg,
   output i2cm_pkg::rsp_type result
);

   localparam int HP_W  = i2cm_pkg::HALF_PERIOD_W;
   localparam int EXT_W = (DELAY_BITS > HP_W) ? DELAY_BITS : HP_W;
   localparam int BW    = i2cm_pkg::BYTE_W;
   localparam int CW    = i2cm_pkg::BIT_COUNT_W;
   localparam int TW    = i2cm_pkg::ACK_TIMEOUT_W;

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_WR_SET, PH_WR_HI, PH_WR_LO,
      PH_AK_REL, PH_AK_POLL, PH_RD_LO, PH_RD_HI, PH_AO1, PH_AO2
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [CW-1:0]         bit_count_ff, bit_count_in;
   logic [BW-1:0]         shift_byte_ff, shift_byte_in;
   logic [DELAY_BITS-1:0] wait_count_ff, wait_count_in;
   logic [TW-1:0]         poll_count_ff, poll_count_in;
   logic                  scl_level_ff, scl_level_in;
   logic                  sda_level_ff, sda_level_in;
   logic                  ack_choice_ff, ack_choice_in;
   logic                  ack_fail_ff, ack_fail_in;
   logic [BW-1:0]         rx_hold_ff, rx_hold_in;
   logic                  done;

   logic [HP_W-1:0]       hp_m1;
   logic [EXT_W-1:0]      hp_ext;
   logic [DELAY_BITS-1:0] delay_load;
   logic [CW-1:0]         bit_count_inc;
   logic [TW-1:0]         poll_count_inc;
   logic [BW-1:0]         shift_wr;

   // A zero half period behaves as one; long delays saturate at the counter width.
   always_comb begin
      hp_m1  = (cfg.half_period == '0) ? '0 : cfg.half_period - HP_W'(1);
      hp_ext = EXT_W'(hp_m1);
      if (hp_ext > EXT_W'({DELAY_BITS{1'b1}})) begin
         delay_load = '1;
      end else begin
         delay_load = DELAY_BITS'(hp_ext);
      end
   end

   assign bit_count_inc  = bit_count_ff + CW'(1);
   assign poll_count_inc = poll_count_ff + TW'(1);
   assign shift_wr       = {shift_byte_ff[BW-2:0], 1'b0};

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_byte_in = shift_byte_ff;
      wait_count_in = wait_count_ff;
      poll_count_in = poll_count_ff;
      scl_level_in  = scl_level_ff;
      sda_level_in  = sda_level_ff;
      ack_choice_in = ack_choice_ff;
      ack_fail_in   = ack_fail_ff;
      rx_hold_in    = rx_hold_ff;
      done          = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (req.cmd_valid) begin
            ack_choice_in = req.send_ack;
            bit_count_in  = '0;
            wait_count_in = delay_load;
            case (req.operation)
               i2cm_pkg::OP_START: begin
                  sda_level_in = 1'b1;
                  scl_level_in = 1'b1;
                  phase_in     = PH_ST1;
               end
               i2cm_pkg::OP_STOP: begin
                  scl_level_in = 1'b0;
                  sda_level_in = 1'b0;
                  phase_in     = PH_SP1;
               end
               i2cm_pkg::OP_WRITE: begin
                  ack_fail_in   = 1'b0;
                  shift_byte_in = req.tx_data;
                  scl_level_in  = 1'b0;
                  sda_level_in  = req.tx_data[BW-1];
                  phase_in      = PH_WR_SET;
               end
               default: begin
                  shift_byte_in = '0;
                  scl_level_in  = 1'b0;
                  sda_level_in  = 1'b1;
                  phase_in      = PH_RD_LO;
               end
            endcase
         end
      end else if (wait_count_ff != '0) begin
         wait_count_in = wait_count_ff - DELAY_BITS'(1);
      end else begin
         unique case (phase_ff)
            PH_ST1: begin
               sda_level_in  = 1'b0;
               wait_count_in = delay_load;
               phase_in      = PH_ST2;
            end
            PH_ST2, PH_AO2: begin
               scl_level_in = 1'b0;
               done         = 1'b1;
               phase_in     = PH_IDLE;
            end
            PH_SP1: begin
               scl_level_in  = 1'b1;
               sda_level_in  = 1'b1;
               wait_count_in = delay_load;
               phase_in      = PH_SP2;
            end
            PH_SP2: begin
               done     = 1'b1;
               phase_in = PH_IDLE;
            end
            PH_WR_SET: begin
               scl_level_in  = 1'b1;
               wait_count_in = delay_load;
               phase_in      = PH_WR_HI;
            end
            PH_WR_HI: begin
               scl_level_in  = 1'b0;
               wait_count_in = delay_load;
               phase_in      = PH_WR_LO;
            end
            PH_WR_LO: begin
               shift_byte_in = shift_wr;
               bit_count_in  = bit_count_inc;
               if (bit_count_inc < i2cm_pkg::BITS_PER_BYTE) begin
                  sda_level_in  = shift_wr[BW-1];
                  wait_count_in = delay_load;
                  phase_in      = PH_WR_SET;
               end else begin
                  sda_level_in  = 1'b1;
                  wait_count_in = '0;
                  phase_in      = PH_AK_REL;
               end
            end
            PH_AK_REL: begin
               scl_level_in  = 1'b1;
               wait_count_in = '0;
               poll_count_in = '0;
               phase_in      = PH_AK_POLL;
            end
            PH_AK_POLL: begin
               if (!req.sda_in) begin
                  scl_level_in = 1'b0;
                  done         = 1'b1;
                  phase_in     = PH_IDLE;
               end else begin
                  poll_count_in = poll_count_inc;
                  // No acknowledge within the timeout: flag it and release the bus.
                  if (poll_count_inc >= cfg.ack_timeout) begin
                     ack_fail_in   = 1'b1;
                     scl_level_in  = 1'b0;
                     sda_level_in  = 1'b0;
                     wait_count_in = delay_load;
                     phase_in      = PH_SP1;
                  end
               end
            end
            PH_RD_LO: begin
               scl_level_in  = 1'b1;
               shift_byte_in = {shift_byte_ff[BW-2:0], req.sda_in};
               wait_count_in = delay_load;
               phase_in      = PH_RD_HI;
            end
            PH_RD_HI: begin
               bit_count_in  = bit_count_inc;
               scl_level_in  = 1'b0;
               wait_count_in = delay_load;
               if (bit_count_inc < i2cm_pkg::BITS_PER_BYTE) begin
                  sda_level_in = 1'b1;
                  phase_in     = PH_RD_LO;
               end else begin
                  rx_hold_in   = shift_byte_ff;
                  sda_level_in = !ack_choice_ff;
                  phase_in     = PH_AO1;
               end
            end
            PH_AO1: begin
               scl_level_in  = 1'b1;
               wait_count_in = delay_load;
               phase_in      = PH_AO2;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         shift_byte_ff <= '0;
         wait_count_ff <= '0;
         poll_count_ff <= '0;
         scl_level_ff  <= 1'b1;
         sda_level_ff  <= 1'b1;
         ack_choice_ff <= 1'b0;
         ack_fail_ff   <= 1'b0;
         rx_hold_ff    <= '0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shift_byte_ff <= shift_byte_in;
         wait_count_ff <= wait_count_in;
         poll_count_ff <= poll_count_in;
         scl_level_ff  <= scl_level_in;
         sda_level_ff  <= sda_level_in;
         ack_choice_ff <= ack_choice_in;
         ack_fail_ff   <= ack_fail_in;
         rx_hold_ff    <= rx_hold_in;
      end
   end

   always_comb begin
      result.scl_out   = scl_level_in;
      result.sda_out   = sda_level_in;
      result.busy_res  = (phase_in != PH_IDLE);
      result.done_res  = done;
      result.rx_data   = rx_hold_in;
      result.ack_error = ack_fail_in;
   end

   `I2CM_ASSERT_NEXT(a_ack_seen_ends, clock, reset,
      step_en && phase_ff == PH_AK_POLL && wait_count_ff == '0 && !req.sda_in,
      phase_ff == PH_IDLE, "acknowledge seen but the write did not finish")
   `I2CM_ASSERT_SAME(a_fail_from_poll, clock, reset, $rose(ack_fail_ff),
      $past(phase_ff) == PH_AK_POLL, "ack error raised outside the acknowledge poll")
   `I2CM_ASSERT_SAME(a_bit_count_range, clock, reset, 1'b1,
      bit_count_ff <= i2cm_pkg::BITS_PER_BYTE, "bit counter ran past one byte")

endmodule

>>> rtl/core/i2cm_rsp_reg.sv
// Result register that decouples the tick stream from the result consumer.
module i2cm_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  i2cm_pkg::rsp_type load_data,
   output logic              can_load,
   i2cm_chan_if.source       rsp_ch
);

   logic              valid_ff, valid_in;
   i2cm_pkg::rsp_type data_ff;

   // A new result may enter when the register is empty or the held one leaves in the same cycle.
   assign can_load = !valid_ff || rsp_ch.ready;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_ch.valid   = valid_ff;
   assign rsp_ch.payload = data_ff;

endmodule

>>> rtl/core/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine. Each transfer on req_ch is one bus tick: it
// samples SDA and, while the engine is idle, may start a start, stop, write-byte or
// read-byte sequence. Every accepted tick yields exactly one result on rsp_ch with the
// SCL/SDA levels to drive, busy and done flags, the last received byte and the acknowledge
// error flag. The engine takes one tick per clock cycle; its result is held in the output
// register and appears on rsp_ch in the cycle after the tick is accepted. The tick rate
// drops only while rsp_ch holds a result that is not taken. Bus delays last half_period
// ticks (0 acts as 1) and the acknowledge poll gives up after ack_timeout high samples.
// The user writes csr_ port registers only while idle; the block does not enforce it.
module i2c_master_bit_engine #(
   parameter int DELAY_BITS = i2cm_pkg::DELAY_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   i2cm_chan_if.sink                       req_ch,
   i2cm_chan_if.source                     rsp_ch,
   input  logic                            csr_we,
   input  i2cm_pkg::csr_index_type         csr_index,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   i2cm_pkg::cfg_type cfg;
   i2cm_pkg::rsp_type step_result;
   logic              can_load;
   logic              step_en;

   assign req_ch.ready = can_load;
   assign step_en      = req_ch.valid && can_load;

   i2cm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2cm_step #(
      .DELAY_BITS (DELAY_BITS)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (req_ch.payload),
      .cfg     (cfg),
      .result  (step_result)
   );

   i2cm_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step_en),
      .load_data (step_result),
      .can_load  (can_load),
      .rsp_ch    (rsp_ch)
   );

endmodule

>>> sim/i2c_master_bit_engine_test.sv
// Self-checking testbench for the I2C master bit engine: bus ticks with a predicted pin model.
`timescale 1ns / 1ps

module i2c_master_bit_engine_test;
   import i2cm_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_WR_SET, PH_WR_HI, PH_WR_LO,
      PH_AK_REL, PH_AK_POLL, PH_RD_LO, PH_RD_HI, PH_AO1, PH_AO2
   } bus_phase_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   i2cm_chan_if #(.payload_type(req_type)) req_if ();
   i2cm_chan_if #(.payload_type(rsp_type)) rsp_if ();

   i2c_master_bit_engine uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Predicted engine state and register copies.
   logic [HALF_PERIOD_W-1:0] half_period;
   logic [ACK_TIMEOUT_W-1:0] ack_timeout;
   bus_phase_type            phase;
   logic [BIT_COUNT_W-1:0]   bit_count;
   logic [BYTE_W-1:0]        shift_byte;
   logic [HALF_PERIOD_W-1:0] wait_left;
   logic [7:0]               poll_count;
   logic                     scl_level;
   logic                     sda_level;
   logic                     ack_choice;
   logic                     ack_fail;
   logic [BYTE_W-1:0]        rx_hold;

   rsp_type levels_due[$];
   int      errors;
   int      items_sent;
   int      ack_chance;
   int      rsp_stall;
   bit      send_calm;
   bit      recv_calm;
   bit      no_idle;

   function automatic logic [HALF_PERIOD_W-1:0] delay_reload();
      return (half_period == 0) ? '0 : half_period - 1'b1;
   endfunction

   // Advances the predicted engine by one bus tick and returns the levels it drives.
   function automatic rsp_type predict_tick(req_type r);
      rsp_type o;
      logic    finished;
      finished = 1'b0;
      if (phase == PH_IDLE) begin
         if (r.cmd_valid) begin
            ack_choice = r.send_ack;
            bit_count = '0;
            case (r.operation)
               OP_START: begin
                  sda_level = 1'b1;
                  scl_level = 1'b1;
                  wait_left = delay_reload();
                  phase = PH_ST1;
               end
               OP_STOP: begin
                  scl_level = 1'b0;
                  sda_level = 1'b0;
                  wait_left = delay_reload();
                  phase = PH_SP1;
               end
               OP_WRITE: begin
                  ack_fail = 1'b0;
                  shift_byte = r.tx_data;
                  scl_level = 1'b0;
                  sda_level = r.tx_data[7];
                  wait_left = delay_reload();
                  phase = PH_WR_SET;
               end
               default: begin
                  shift_byte = '0;
                  scl_level = 1'b0;
                  sda_level = 1'b1;
                  wait_left = delay_reload();
                  phase = PH_RD_LO;
               end
            endcase
         end
      end else if (wait_left != 0) begin
         wait_left = wait_left - 1'b1;
      end else begin
         case (phase)
            PH_ST1: begin
               sda_level = 1'b0;
               wait_left = delay_reload();
               phase = PH_ST2;
            end
            PH_ST2: begin
               scl_level = 1'b0;
               phase = PH_IDLE;
               finished = 1'b1;
            end
            PH_SP1: begin
               scl_level = 1'b1;
               sda_level = 1'b1;
               wait_left = delay_reload();
               phase = PH_SP2;
            end
            PH_SP2: begin
               phase = PH_IDLE;
               finished = 1'b1;
            end
            PH_WR_SET: begin
               scl_level = 1'b1;
               wait_left = delay_reload();
               phase = PH_WR_HI;
            end
            PH_WR_HI: begin
               scl_level = 1'b0;
               wait_left = delay_reload();
               phase = PH_WR_LO;
            end
            PH_WR_LO: begin
               shift_byte = {shift_byte[6:0], 1'b0};
               bit_count = bit_count + 1'b1;
               if (bit_count < BITS_PER_BYTE) begin
                  sda_level = shift_byte[7];
                  wait_left = delay_reload();
                  phase = PH_WR_SET;
               end else begin
                  sda_level = 1'b1;
                  wait_left = '0;
                  phase = PH_AK_REL;
               end
            end
            PH_AK_REL: begin
               scl_level = 1'b1;
               wait_left = '0;
               poll_count = '0;
               phase = PH_AK_POLL;
            end
            PH_AK_POLL: begin
               if (!r.sda_in) begin
                  scl_level = 1'b0;
                  phase = PH_IDLE;
                  finished = 1'b1;
               end else begin
                  poll_count = poll_count + 1'b1;
                  // No acknowledge in time: flag it and fall into the stop sequence.
                  if (poll_count >= ack_timeout) begin
                     ack_fail = 1'b1;
                     scl_level = 1'b0;
                     sda_level = 1'b0;
                     wait_left = delay_reload();
                     phase = PH_SP1;
                  end
               end
            end
            PH_RD_LO: begin
               scl_level = 1'b1;
               shift_byte = {shift_byte[6:0], r.sda_in};
               wait_left = delay_reload();
               phase = PH_RD_HI;
            end
            PH_RD_HI: begin
               bit_count = bit_count + 1'b1;
               scl_level = 1'b0;
               if (bit_count < BITS_PER_BYTE) begin
                  sda_level = 1'b1;
                  wait_left = delay_reload();
                  phase = PH_RD_LO;
               end else begin
                  rx_hold = shift_byte;
                  sda_level = !ack_choice;
                  wait_left = delay_reload();
                  phase = PH_AO1;
               end
            end
            PH_AO1: begin
               scl_level = 1'b1;
               wait_left = delay_reload();
               phase = PH_AO2;
            end
            PH_AO2: begin
               scl_level = 1'b0;
               phase = PH_IDLE;
               finished = 1'b1;
            end
            default: phase = PH_IDLE;
         endcase
      end
      o.scl_out = scl_level;
      o.sda_out = sda_level;
      o.busy_res = (phase != PH_IDLE);
      o.done_res = finished;
      o.rx_data = rx_hold;
      o.ack_error = ack_fail;
      return o;
   endfunction

   function automatic int slave_ack_chance();
      case ($urandom_range(0, 9))
         0:       return 0;
         1, 2:    return 20;
         default: return 100;
      endcase
   endfunction

   // Sends one bus tick after a random gap and records the levels it should produce.
   task automatic drive_tick(logic cmd, op_type op, logic [BYTE_W-1:0] data, logic ack);
      req_type r;
      int      gap;
      r.cmd_valid = cmd;
      r.operation = op;
      r.tx_data = data;
      r.send_ack = ack;
      // The slave answers the acknowledge poll; elsewhere SDA is random.
      if (phase == PH_AK_POLL)
         r.sda_in = ($urandom_range(0, 99) < ack_chance) ? 1'b0 : 1'b1;
      else
         r.sda_in = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      gap = (no_idle || send_calm) ? 0 : $urandom_range(0, 18);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (!req_if.ready);
      levels_due.push_back(predict_tick(r));
      items_sent++;
   endtask

   task automatic noise_tick(logic cmd);
      drive_tick(cmd, op_type'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
   endtask

   // Issues a command on an idle engine and keeps the bus ticking until it finishes.
   // Commands offered while the engine is busy must be ignored.
   task automatic run_command(op_type op, logic [BYTE_W-1:0] data, logic ack, int chance);
      ack_chance = chance;
      drive_tick(1'b1, op, data, ack);
      while (phase != PH_IDLE) noise_tick($urandom_range(0, 9) == 0);
      repeat ($urandom_range(0, 2)) noise_tick(1'b0);
   endtask

   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (levels_due.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      settle();
      csr_index <= idx;
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_HALF_PERIOD) half_period = value;
      else ack_timeout = value[ACK_TIMEOUT_W-1:0];
   endtask

   task automatic test_reset_values();
      run_command(OP_START, 8'h00, 1'b0, 100);
      run_command(OP_WRITE, 8'hA5, 1'b0, 100);
      run_command(OP_READ, 8'hFF, 1'b1, 100);
      run_command(OP_READ, 8'h00, 1'b0, 100);
      run_command(OP_STOP, 8'h00, 1'b0, 100);
   endtask

   task automatic test_write_patterns();
      write_register(CSR_HALF_PERIOD, 16'd1);
      run_command(OP_START, 8'hFF, 1'b1, 100);
      run_command(OP_WRITE, 8'h00, 1'b0, 100);
      run_command(OP_WRITE, 8'hFF, 1'b1, 30);
      // The slave never acknowledges, so the full timeout runs out.
      run_command(OP_WRITE, 8'h5A, 1'b0, 0);
      run_command(OP_WRITE, 8'h3C, 1'b0, 100);
      run_command(OP_STOP, 8'h00, 1'b0, 100);
   endtask

   task automatic test_zero_half_period();
      write_register(CSR_HALF_PERIOD, 16'd0);
      run_command(OP_START, 8'h00, 1'b0, 100);
      run_command(OP_WRITE, 8'h80, 1'b0, 100);
      run_command(OP_READ, 8'h00, 1'b1, 100);
      run_command(OP_STOP, 8'h00, 1'b0, 100);
   endtask

   task automatic test_ack_timeout();
      // A zero timeout gives up on the first high sample; upper data bits are dropped.
      write_register(CSR_ACK_TIMEOUT, 16'hFF00);
      run_command(OP_WRITE, 8'h01, 1'b0, 0);
      write_register(CSR_ACK_TIMEOUT, 16'h0001);
      run_command(OP_WRITE, 8'hFE, 1'b0, 0);
      run_command(OP_WRITE, 8'h7F, 1'b1, 30);
      write_register(CSR_ACK_TIMEOUT, 16'h00FF);
      run_command(OP_WRITE, 8'hC3, 1'b0, 0);
   endtask

   task automatic test_long_half_period();
      write_register(CSR_HALF_PERIOD, 16'd64);
      no_idle = 1'b1;
      run_command(OP_START, 8'h00, 1'b0, 100);
      settle();
      no_idle = 1'b0;
   endtask

   task automatic test_random_traffic();
      int               n;
      logic [BYTE_W-1:0] addr;
      while (items_sent < 1450) begin
         case ($urandom_range(0, 5))
            0:       write_register(CSR_HALF_PERIOD, 16'd0);
            1, 2:    write_register(CSR_HALF_PERIOD, 16'd1);
            default: write_register(CSR_HALF_PERIOD, 16'($urandom_range(2, 6)));
         endcase
         write_register(CSR_ACK_TIMEOUT, {8'($urandom), ($urandom_range(0, 3) == 0) ?
                        8'($urandom_range(0, 4)) : 8'($urandom_range(5, 255))});
         for (int t = $urandom_range(2, 4); t > 0 && items_sent < 1450; t--) begin
            if ($urandom_range(0, 4) == 0) begin
               // Commands in arbitrary order, without regard to bus framing.
               repeat ($urandom_range(1, 3))
                  run_command(op_type'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                              slave_ack_chance());
            end else begin
               addr = 8'($urandom);
               run_command(OP_START, 8'($urandom), 1'($urandom), 100);
               run_command(OP_WRITE, addr, 1'($urandom), slave_ack_chance());
               n = $urandom_range(1, 3);
               for (int k = 0; k < n; k++) begin
                  if (addr[0])
                     run_command(OP_READ, 8'($urandom), k < n - 1, 100);
                  else
                     run_command(OP_WRITE, 8'($urandom), 1'($urandom), slave_ack_chance());
               end
               run_command(OP_STOP, 8'($urandom), 1'($urandom), 100);
            end
         end
      end
   endtask

   function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (levels_due.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = levels_due.pop_front();
            compare_field("scl_out", want.scl_out, got.scl_out);
            compare_field("sda_out", want.sda_out, got.sda_out);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("rx_data", want.rx_data, got.rx_data);
            compare_field("ack_error", want.ack_error, got.ack_error);
         end
         if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
         rsp_stall = (no_idle || recv_calm) ? 0 : $urandom_range(0, 18);
      end
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      #40_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_HALF_PERIOD;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      half_period = HALF_PERIOD_RESET;
      ack_timeout = ACK_TIMEOUT_RESET;
      phase = PH_IDLE;
      bit_count = '0;
      shift_byte = '0;
      wait_left = '0;
      poll_count = '0;
      scl_level = 1'b1;
      sda_level = 1'b1;
      ack_choice = 1'b0;
      ack_fail = 1'b0;
      rx_hold = '0;
      errors = 0;
      items_sent = 0;
      ack_chance = 100;
      rsp_stall = 0;
      send_calm = 1'b0;
      recv_calm = 1'b0;
      no_idle = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_write_patterns();
      test_zero_half_period();
      test_ack_timeout();
      test_long_half_period();
      test_random_traffic();

      settle();
      repeat (6) @(posedge clock);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
